[rtl/core/tccw_pkg.sv]
package tccw_pkg;

  localparam int CHAR_W = 8;
  localparam int CELL_CHAR_W = 7;
  localparam int ATTR_W = 8;
  localparam int POS_W = 11;
  // wide enough for row * columns + column at the default screen size
  localparam int LIN_W = 13;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CELL_CHAR_W-1:0] CODE_SPACE = 7'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;
  localparam int DEF_TAB_STOP = 8;

endpackage

[rtl/core/text_console_char_writer.sv]
// channel  direction  ports                                   accepted when
// in       input      in_valid, in_ready, in_char_code        in_valid & in_ready
// out      output     out_valid, out_ready, out_cell_*,       out_valid & out_ready
//                     out_scroll_up, out_cursor_pos
// cfg      input      cfg_wr_en, cfg_wr_data                  cfg_wr_en
//
// One item per cycle unless the output stalls; the result lands in the output
// register in the cycle after acceptance. Cursor update, tab table lookup and
// row * columns product: one combinational pass, cursor state to that register.
// Synchronous active-low reset: cursor at 0,0, attribute 15, no result pending.
// A stalled result holds; a new item is taken in the cycle the result leaves.
module text_console_char_writer #(
  parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS,
  parameter int TAB_STOP = tccw_pkg::DEF_TAB_STOP
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tccw_pkg::CHAR_W-1:0]       in_char_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_cell_write,
  output logic [tccw_pkg::POS_W-1:0]        out_cell_index,
  output logic [tccw_pkg::CELL_CHAR_W-1:0]  out_cell_char,
  output logic [tccw_pkg::ATTR_W-1:0]       out_cell_attr,
  output logic                              out_scroll_up,
  output logic [tccw_pkg::POS_W-1:0]        out_cursor_pos,
  input  logic                              cfg_wr_en,
  input  logic [tccw_pkg::ATTR_W-1:0]       cfg_wr_data
);
  import tccw_pkg::*;

  localparam int COL_W = $clog2(SCREEN_COLS);
  localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int TAB_W = COL_W + 1;
  localparam int COL_N = 1 << COL_W;

  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [ATTR_W-1:0]      attr_r;
  logic                   out_valid_r;
  logic                   wr_r, wr_nxt;
  logic [POS_W-1:0]       idx_r, idx_nxt;
  logic [CELL_CHAR_W-1:0] chr_r, chr_nxt;
  logic [ATTR_W-1:0]      oattr_r, oattr_nxt;
  logic                   scroll_r, scroll_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  logic [TAB_W-1:0] tab_lut [COL_N];
  logic [TAB_W-1:0] col_wide;
  logic [ROW_W:0]   row_wide;
  logic             in_acc;

  for (genvar c = 0; c < COL_N; c++) begin : g_tab
    assign tab_lut[c] = TAB_W'(((c + TAB_STOP - 1) / TAB_STOP) * TAB_STOP + 1);
  end

  function automatic logic [POS_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    logic [LIN_W-1:0] sum;
    sum = LIN_W'(row) * LIN_W'(SCREEN_COLS) + LIN_W'(col);
    return sum[POS_W-1:0];
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc = in_valid && in_ready;

  always_comb begin
    wr_nxt = 1'b0;
    idx_nxt = '0;
    chr_nxt = '0;
    col_wide = {1'b0, col_r};
    row_wide = {1'b0, row_r};
    case (in_char_code)
      CODE_NEWLINE: begin
        col_wide = '0;
        row_wide = row_wide + 1'b1;
      end
      CODE_BACKSPACE: begin
        if (col_r != '0) begin
          col_wide = col_wide - 1'b1;
        end
        wr_nxt = 1'b1;
        idx_nxt = lin_pos(row_r, col_wide[COL_W-1:0]);
        chr_nxt = CODE_SPACE;
      end
      CODE_TAB: begin
        col_wide = tab_lut[col_r];
      end
      default: begin
        if (!in_char_code[CHAR_W-1]) begin
          wr_nxt = 1'b1;
          idx_nxt = lin_pos(row_r, col_r);
          chr_nxt = in_char_code[CELL_CHAR_W-1:0];
        end
        col_wide = col_wide + 1'b1;
      end
    endcase
    if (col_wide >= TAB_W'(SCREEN_COLS)) begin
      col_wide = '0;
      row_wide = row_wide + 1'b1;
    end
    scroll_nxt = 1'b0;
    if (row_wide >= (ROW_W+1)'(SCREEN_ROWS)) begin
      row_wide = (ROW_W+1)'(SCREEN_ROWS - 1);
      scroll_nxt = 1'b1;
    end
    col_nxt = col_wide[COL_W-1:0];
    row_nxt = row_wide[ROW_W-1:0];
    oattr_nxt = wr_nxt ? attr_r : '0;
    pos_nxt = lin_pos(row_nxt, col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      attr_r <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_r <= wr_nxt;
      idx_r <= idx_nxt;
      chr_r <= chr_nxt;
      oattr_r <= oattr_nxt;
      scroll_r <= scroll_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cell_write = wr_r;
  assign out_cell_index = idx_r;
  assign out_cell_char = chr_r;
  assign out_cell_attr = oattr_r;
  assign out_scroll_up = scroll_r;
  assign out_cursor_pos = pos_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ROW_W+1)'(row_r) < (ROW_W+1)'(SCREEN_ROWS) && TAB_W'(col_r) < TAB_W'(SCREEN_COLS))
    else $error("cursor out of screen");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cell_write |-> out_cell_index == '0 && out_cell_char == '0
      && out_cell_attr == '0)
    else $error("idle cell fields not cleared");

  a_newline_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_char_code == CODE_NEWLINE
      && (ROW_W+1)'(row_r) < (ROW_W+1)'(SCREEN_ROWS - 1)
    |=> col_r == '0 && row_r == $past(row_r) + 1'b1 && !out_scroll_up)
    else $error("newline did not step the row");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tccw_pkg::*;

  localparam int COLS = DEF_SCREEN_COLS;
  localparam int ROWS = DEF_SCREEN_ROWS;
  localparam int TAB = DEF_TAB_STOP;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                   cell_write;
    logic [POS_W-1:0]       cell_index;
    logic [CELL_CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0]      cell_attr;
    logic                   scroll_up;
    logic [POS_W-1:0]       cursor_pos;
  } console_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CHAR_W-1:0]      in_char_code = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_cell_write;
  logic [POS_W-1:0]       out_cell_index;
  logic [CELL_CHAR_W-1:0] out_cell_char;
  logic [ATTR_W-1:0]      out_cell_attr;
  logic                   out_scroll_up;
  logic [POS_W-1:0]       out_cursor_pos;
  logic                   cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0]      cfg_wr_data = '0;

  // predictor state
  int              model_col;
  int              model_row;
  logic [ATTR_W-1:0] model_attr;

  console_result_t expected_cells[$];
  console_result_t want;
  console_result_t got;
  int              errors = 0;
  int              cycle_count = 0;
  bit              sink_steady = 1'b0;
  int              burst_len;
  int              stall_len;

  text_console_char_writer #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS),
    .TAB_STOP(TAB)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cell_write(out_cell_write),
    .out_cell_index(out_cell_index),
    .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr),
    .out_scroll_up(out_scroll_up),
    .out_cursor_pos(out_cursor_pos),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic console_result_t predict_console_step(input logic [CHAR_W-1:0] code);
    console_result_t r;
    r = '0;
    if (code == CODE_NEWLINE) begin
      model_col = 0;
      model_row++;
    end else if (code == CODE_BACKSPACE) begin
      if (model_col > 0) model_col--;
      r.cell_write = 1'b1;
      r.cell_index = POS_W'(model_row * COLS + model_col);
      r.cell_char = CODE_SPACE;
      r.cell_attr = model_attr;
    end else begin
      if (code == CODE_TAB) begin
        model_col = ((model_col + TAB - 1) / TAB) * TAB + 1;
      end else begin
        if (code < 128) begin
          r.cell_write = 1'b1;
          r.cell_index = POS_W'(model_row * COLS + model_col);
          r.cell_char = code[CELL_CHAR_W-1:0];
          r.cell_attr = model_attr;
        end
        model_col++;
      end
      if (model_col >= COLS) begin
        model_col = 0;
        model_row++;
      end
    end
    if (model_row >= ROWS) begin
      model_row = ROWS - 1;
      r.scroll_up = 1'b1;
    end
    r.cursor_pos = POS_W'(model_row * COLS + model_col);
    return r;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pick_pause(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, longest);
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CODE_NEWLINE;
    if (r < 25) return CODE_BACKSPACE;
    if (r < 37) return CODE_TAB;
    if (r < 47) return CHAR_W'($urandom_range(128, 255));
    return CHAR_W'($urandom_range(0, 127));
  endfunction

  // result checking, then prediction of the item taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_cell_write, out_cell_index, out_cell_char, out_cell_attr,
                out_scroll_up, out_cursor_pos};
        if (expected_cells.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", got);
          errors++;
        end else begin
          want = expected_cells.pop_front();
          if (got.cell_write !== want.cell_write || got.cell_index !== want.cell_index ||
              got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
              got.scroll_up !== want.scroll_up || got.cursor_pos !== want.cursor_pos) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, got);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_cells.push_back(predict_console_step(in_char_code));
    end
  end

  // result sink back-pressure
  initial begin
    @(negedge clk);
    forever begin
      burst_len = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (burst_len) @(negedge clk);
      stall_len = sink_steady ? 0 : pick_pause(30);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] code, input bit steady);
    int gap;
    gap = steady ? 0 : pick_pause(25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_cells.size() != 0 || out_valid) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_text_attribute(input logic [ATTR_W-1:0] value);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_attr = value;
  endtask

  task automatic test_printable_extremes();
    send_char(8'd0, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd128, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(8'd32, 1'b0);
  endtask

  task automatic test_control_codes();
    send_char(CODE_BACKSPACE, 1'b0);
    send_char(CODE_NEWLINE, 1'b0);
    // backspace at column 0 holds there
    send_char(CODE_BACKSPACE, 1'b0);
    send_char(CODE_TAB, 1'b0);
    send_char(CODE_TAB, 1'b0);
    send_char(CODE_TAB, 1'b0);
  endtask

  // tabs across a whole row until the column wraps
  task automatic test_tab_wrap();
    send_char(CODE_NEWLINE, 1'b0);
    repeat (11) send_char(CODE_TAB, 1'b0);
  endtask

  task automatic test_random_text(input int count, input bit steady);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        // a long printable line, can wrap the row
        run = $urandom_range(60, 100);
        repeat (run) send_char(CHAR_W'($urandom_range(32, 126)), steady);
        sent += run;
      end else begin
        send_char(random_char(), steady);
        sent++;
      end
    end
  endtask

  initial begin
    model_col = 0;
    model_row = 0;
    model_attr = ATTR_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_printable_extremes();
    test_control_codes();
    test_tab_wrap();

    set_text_attribute(8'h00);
    test_random_text(150, 1'b0);
    set_text_attribute(8'hFF);
    test_random_text(150, 1'b0);
    set_text_attribute(ATTR_W'($urandom_range(1, 254)));
    sink_steady = 1'b1;
    test_random_text(150, 1'b1);
    sink_steady = 1'b0;
    set_text_attribute(ATTR_RESET);
    test_random_text(200, 1'b0);

    wait_drain();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tccw_pkg.sv
rtl/core/text_console_char_writer.sv
tb/tb_top.sv
